// ===== sv/lpfr_pkg.sv =====
// Shared constants, types and handshake structs of the LRU page frame replacer.
package lpfr_pkg;

  localparam int FRAMES        = 8;
  localparam int PAGE_BITS     = 16;
  localparam int STAMP_BITS    = 32;
  localparam int FAULT_BITS    = 32;
  localparam int CFG_BITS      = 4;
  localparam int IN_PAGE_BITS  = 16;
  localparam int OUT_IDX_BITS  = 3;
  localparam int OUT_PAGE_BITS = 16;

  localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_BITS = $clog2(FRAMES + 1);

  localparam logic [CFG_BITS-1:0]   FIU_RESET = CFG_BITS'(8);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_HIT,
    ST_SCAN_LRU,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hit_step;
    logic hit_found;
    logic lru_start;
    logic lru_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic lru_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/lpfr_ctrl.sv =====
// Controller state machine: sequences the hit scan, the LRU scan and the commit.
module lpfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpfr_pkg::status_t status,
  output lpfr_pkg::cmd_t    cmd
);

  lpfr_pkg::state_t state;
  lpfr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lpfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lpfr_pkg::ST_SCAN_HIT;
        end
      end
      lpfr_pkg::ST_SCAN_HIT: begin
        if (status.match) begin
          cmd.hit_found = 1'b1;
          state_next    = lpfr_pkg::ST_COMMIT;
        end else if (status.last) begin
          cmd.lru_start = 1'b1;
          state_next    = lpfr_pkg::ST_SCAN_LRU;
        end else begin
          cmd.hit_step = 1'b1;
        end
      end
      lpfr_pkg::ST_SCAN_LRU: begin
        if (status.lru_done) begin
          state_next = lpfr_pkg::ST_COMMIT;
        end else begin
          cmd.lru_step = 1'b1;
        end
      end
      lpfr_pkg::ST_COMMIT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lpfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lpfr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lpfr_dpath.sv =====
// Datapath: frame table, scan pointer, use clock, fault counter and output register.
module lpfr_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [lpfr_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic [lpfr_pkg::IN_PAGE_BITS-1:0]   page_number,
  input  lpfr_pkg::cmd_t                      cmd,
  output lpfr_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                page_hit,
  output logic [lpfr_pkg::OUT_IDX_BITS-1:0]   frame_index,
  output logic                                evicted_valid,
  output logic [lpfr_pkg::OUT_PAGE_BITS-1:0]  evicted_page,
  output logic [lpfr_pkg::FAULT_BITS-1:0]     fault_total
);

  logic [lpfr_pkg::CFG_BITS-1:0]   frames_in_use;
  logic [lpfr_pkg::PAGE_BITS-1:0]  page_req;
  logic [lpfr_pkg::CNT_BITS-1:0]   scan;
  logic [lpfr_pkg::IDX_BITS-1:0]   slot;
  logic                            hit_r;
  logic [lpfr_pkg::STAMP_BITS-1:0] best_stamp;
  logic [lpfr_pkg::PAGE_BITS-1:0]  frame_page [lpfr_pkg::FRAMES];
  logic                            frame_valid [lpfr_pkg::FRAMES];
  logic [lpfr_pkg::STAMP_BITS-1:0] last_use_stamp [lpfr_pkg::FRAMES];
  logic [lpfr_pkg::STAMP_BITS-1:0] use_clock;
  logic [lpfr_pkg::FAULT_BITS-1:0] fault_count;

  logic [lpfr_pkg::CNT_BITS-1:0]   n_active;
  logic [lpfr_pkg::IDX_BITS-1:0]   scan_idx;
  logic [lpfr_pkg::STAMP_BITS-1:0] use_clock_next;
  logic [lpfr_pkg::FAULT_BITS-1:0] fault_count_next;

  // clamp the frame count to one..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = lpfr_pkg::CNT_BITS'(1);
    end else if (32'(frames_in_use) > lpfr_pkg::FRAMES) begin
      n_active = lpfr_pkg::CNT_BITS'(lpfr_pkg::FRAMES);
    end else begin
      n_active = lpfr_pkg::CNT_BITS'(frames_in_use);
    end
  end

  assign scan_idx = scan[lpfr_pkg::IDX_BITS-1:0];

  assign use_clock_next   = (use_clock == lpfr_pkg::STAMP_MAX) ?
                            use_clock : use_clock + 1'b1;
  assign fault_count_next = (hit_r || fault_count == lpfr_pkg::FAULT_MAX) ?
                            fault_count : fault_count + 1'b1;

  assign status.match    = frame_valid[scan_idx] && (frame_page[scan_idx] == page_req);
  assign status.last     = (lpfr_pkg::CNT_BITS'(scan + 1'b1) == n_active);
  assign status.lru_done = (scan >= n_active);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpfr_pkg::FIU_RESET;
      scan          <= '0;
      slot          <= '0;
      hit_r         <= 1'b0;
      best_stamp    <= '0;
      use_clock     <= '0;
      fault_count   <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < lpfr_pkg::FRAMES; i++) begin
        frame_valid[i]    <= 1'b0;
        last_use_stamp[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        frames_in_use <= cfg_data;
      end

      if (cmd.load) begin
        page_req <= lpfr_pkg::PAGE_BITS'(page_number);
        scan     <= '0;
        hit_r    <= 1'b0;
      end

      if (cmd.hit_step) begin
        scan <= lpfr_pkg::CNT_BITS'(scan + 1'b1);
      end

      if (cmd.hit_found) begin
        slot  <= scan_idx;
        hit_r <= 1'b1;
      end

      if (cmd.lru_start) begin
        slot       <= '0;
        best_stamp <= last_use_stamp[0];
        scan       <= lpfr_pkg::CNT_BITS'(1);
      end

      if (cmd.lru_step) begin
        // strict compare keeps the lowest index on ties
        if (last_use_stamp[scan_idx] < best_stamp) begin
          slot       <= scan_idx;
          best_stamp <= last_use_stamp[scan_idx];
        end
        scan <= lpfr_pkg::CNT_BITS'(scan + 1'b1);
      end

      if (cmd.commit) begin
        use_clock            <= use_clock_next;
        last_use_stamp[slot] <= use_clock_next;
        fault_count          <= fault_count_next;
        if (!hit_r) begin
          frame_page[slot]  <= page_req;
          frame_valid[slot] <= 1'b1;
        end
        out_valid     <= 1'b1;
        page_hit      <= hit_r;
        frame_index   <= lpfr_pkg::OUT_IDX_BITS'(slot);
        evicted_valid <= !hit_r && frame_valid[slot];
        evicted_page  <= (!hit_r && frame_valid[slot]) ?
                         lpfr_pkg::OUT_PAGE_BITS'(frame_page[slot]) : '0;
        fault_total   <= fault_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/lru_page_frame_replacer.sv =====
// Top level of the LRU page frame replacer: controller plus datapath.
//
// Takes one page reference per request and keeps a fully associative set of
// frames, each with a page number, a valid mark and a last-use stamp. The
// controller first walks the frames in use, one per cycle, looking for a
// resident copy of the page; a hit refreshes that frame's stamp. On a miss it
// walks the frames again, one per cycle, keeping the smallest stamp (lowest
// index on ties, so empty frames fill in order), loads the page there and
// counts a fault. Each request yields exactly one result: hit or fault, the
// frame used, the evicted page (zero when none) and the saturating fault
// total. One request is in work at a time. A hit ends the first walk at the
// frame where it is found, and a fault walks the frames in use twice; the
// single sequential scan pointer over the frame table sets how long a request
// takes. A finished result sits in an output register, so the next request is
// accepted while it waits; the commit of that next request holds until the
// result has been taken. The frame count register (clamped to one..eight) is
// written through the cfg channel, which is always ready and must only be used
// while the block is idle.
module lru_page_frame_replacer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpfr_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lpfr_pkg::IN_PAGE_BITS-1:0]   page_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                page_hit,
  output logic [lpfr_pkg::OUT_IDX_BITS-1:0]   frame_index,
  output logic                                evicted_valid,
  output logic [lpfr_pkg::OUT_PAGE_BITS-1:0]  evicted_page,
  output logic [lpfr_pkg::FAULT_BITS-1:0]     fault_total
);

  lpfr_pkg::cmd_t    cmd;
  lpfr_pkg::status_t status;

  // take configuration writes at any time
  assign cfg_ready = 1'b1;

  lpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lpfr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .page_number   (page_number),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .page_hit      (page_hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

// ===== sv/lpfr_chk.sv =====
// Port-level checker for the LRU page frame replacer, bound to the top level.
module lpfr_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                page_hit,
  input logic [lpfr_pkg::OUT_IDX_BITS-1:0]   frame_index,
  input logic                                evicted_valid,
  input logic [lpfr_pkg::OUT_PAGE_BITS-1:0]  evicted_page,
  input logic [lpfr_pkg::FAULT_BITS-1:0]     fault_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(page_hit) &&
      $stable(frame_index) && $stable(evicted_page) && $stable(fault_total))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && page_hit |-> !evicted_valid && evicted_page == '0)
    else $error("hit reported an eviction");

  // a fault is always counted
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !page_hit |-> fault_total != '0)
    else $error("fault with zero fault total");

  // frame index stays within the table
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(frame_index) < lpfr_pkg::FRAMES)
    else $error("frame index out of range");

endmodule

bind lru_page_frame_replacer lpfr_chk u_lpfr_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .page_hit      (page_hit),
  .frame_index   (frame_index),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_total   (fault_total)
);
